// ===== rtl/integer_execute_alu_unit_defines.svh =====
// ----------------------------------------------------------------------------
// integer_execute_alu_unit_defines.svh
// Assertion macros for the execute ALU.
// ----------------------------------------------------------------------------
`ifndef INTEGER_EXECUTE_ALU_UNIT_DEFINES_SVH
`define INTEGER_EXECUTE_ALU_UNIT_DEFINES_SVH

// Implication checked every cycle outside reset.
`define IEA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must always hold outside reset.
`define IEA_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== rtl/iea_pkg.sv =====
// ----------------------------------------------------------------------------
// iea_pkg
// Shared constants, operation codes and stage record of the execute ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iea_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int LATENCY    = DATA_WIDTH + 2;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_XOR  = 5'd2;
    localparam logic [4:0] OP_REM  = 5'd3;
    localparam logic [4:0] OP_REMU = 5'd4;
    localparam logic [4:0] OP_EQ   = 5'd5;
    localparam logic [4:0] OP_GE   = 5'd6;
    localparam logic [4:0] OP_GT   = 5'd7;
    localparam logic [4:0] OP_LE   = 5'd8;
    localparam logic [4:0] OP_LT   = 5'd9;
    localparam logic [4:0] OP_NE   = 5'd10;
    localparam logic [4:0] OP_NEG  = 5'd11;
    localparam logic [4:0] OP_MOVE = 5'd12;
    localparam logic [4:0] OP_MUL  = 5'd13;
    localparam logic [4:0] OP_MULU = 5'd14;
    localparam logic [4:0] OP_DIV  = 5'd15;
    localparam logic [4:0] OP_DIVU = 5'd16;
    localparam logic [4:0] OP_ADDR = 5'd17;

    typedef struct packed {
        logic                  valid;
        logic [4:0]            kind;
        logic                  full;
        logic                  neg_q;
        logic                  neg_r;
        logic                  dz;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] quot;
        logic [DATA_WIDTH-1:0] divisor;
        logic [DATA_WIDTH-1:0] res;
        logic [DATA_WIDTH-1:0] high;
    } iea_stage_t;

    function automatic logic is_div_op(input logic [4:0] k);
        return (k == OP_REM) || (k == OP_REMU) || (k == OP_DIV) || (k == OP_DIVU);
    endfunction

endpackage

// ===== rtl/iea_prep.sv =====
// ----------------------------------------------------------------------------
// iea_prep
// Entry stage: decode, simple ALU and compare ops, multiply, divide operand setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iea_prep
    import iea_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [4:0]            kind,
    input  logic [DATA_WIDTH-1:0] src_a,
    input  logic [DATA_WIDTH-1:0] src_b,
    input  logic [DATA_WIDTH-1:0] offset,
    input  logic                  full_width,
    output iea_stage_t            stage_out
);

    localparam int W = DATA_WIDTH;

    iea_stage_t            stage_reg;
    iea_stage_t            stage_next;
    logic                  sgn_mul;
    logic                  sgn_div;
    logic signed [W:0]     mul_a;
    logic signed [W:0]     mul_b;
    logic signed [2*W+1:0] prod;
    logic                  lt_ab;
    logic                  lt_ba;

    always_comb
    begin
        sgn_mul = (kind == OP_MUL);
        sgn_div = (kind == OP_REM) || (kind == OP_DIV);
        mul_a   = $signed({sgn_mul & src_a[W-1], src_a});
        mul_b   = $signed({sgn_mul & src_b[W-1], src_b});
        prod    = mul_a * mul_b;
        lt_ab   = $signed(src_a) < $signed(src_b);
        lt_ba   = $signed(src_b) < $signed(src_a);

        stage_next         = '0;
        stage_next.valid   = take;
        stage_next.kind    = kind;
        stage_next.full    = full_width;
        stage_next.neg_q   = sgn_div & (src_a[W-1] ^ src_b[W-1]);
        stage_next.neg_r   = sgn_div & src_a[W-1];
        stage_next.dz      = is_div_op(kind) && (src_b == '0);
        stage_next.quot    = (sgn_div && src_a[W-1]) ? (W'(0) - src_a) : src_a;
        stage_next.divisor = (sgn_div && src_b[W-1]) ? (W'(0) - src_b) : src_b;

        case (kind)
            OP_ADD:  stage_next.res = src_a + src_b;
            OP_SUB:  stage_next.res = src_a - src_b;
            OP_XOR:  stage_next.res = src_a ^ src_b;
            OP_EQ:   stage_next.res = W'(src_a == src_b);
            OP_GE:   stage_next.res = W'(!lt_ab);
            OP_GT:   stage_next.res = W'(lt_ba);
            OP_LE:   stage_next.res = W'(!lt_ba);
            OP_LT:   stage_next.res = W'(lt_ab);
            OP_NE:   stage_next.res = W'(src_a != src_b);
            OP_NEG:  stage_next.res = W'(0) - src_a;
            OP_MOVE: stage_next.res = src_a;
            OP_MUL, OP_MULU:
            begin
                stage_next.res  = prod[W-1:0];
                stage_next.high = full_width ? prod[2*W-1:W] : '0;
            end
            OP_ADDR: stage_next.res = src_a + offset;
            default: stage_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/iea_div_cell.sv =====
// ----------------------------------------------------------------------------
// iea_div_cell
// One restoring division step; passes the request on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iea_div_cell
    import iea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  iea_stage_t stage_in,
    output iea_stage_t stage_out
);

    localparam int W = DATA_WIDTH;

    iea_stage_t    stage_reg;
    iea_stage_t    stage_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted    = {stage_in.rem, stage_in.quot[W-1]};
        diff       = shifted - {1'b0, stage_in.divisor};
        stage_next = stage_in;
        if (!diff[W])
        begin
            stage_next.rem  = diff[W-1:0];
            stage_next.quot = {stage_in.quot[W-2:0], 1'b1};
        end
        else
        begin
            stage_next.rem  = shifted[W-1:0];
            stage_next.quot = {stage_in.quot[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/integer_execute_alu_unit.sv =====
// ----------------------------------------------------------------------------
// integer_execute_alu_unit
// Pipelined execute ALU with multiply and a chain of divide cells.
// ----------------------------------------------------------------------------
// Takes a new request every cycle (busy is always low). Every request, of any
// kind, passes through the whole pipeline, whose depth is set by the divider:
// one entry stage, one restoring cell per quotient bit, one output stage.
// Results leave in request order with a one-cycle done strobe; the receiver
// cannot stall, so capture on done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_execute_alu_unit_defines.svh"

module integer_execute_alu_unit
    import iea_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [4:0]            kind,
    input  logic [DATA_WIDTH-1:0] src_a,
    input  logic [DATA_WIDTH-1:0] src_b,
    input  logic [DATA_WIDTH-1:0] offset,
    input  logic                  full_width,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result,
    output logic [DATA_WIDTH-1:0] high_part,
    output logic                  divide_by_zero
);

    localparam int W = DATA_WIDTH;

    iea_stage_t     chain [0:W];
    iea_stage_t     last;
    logic           done_reg;
    logic [W-1:0]   result_reg;
    logic [W-1:0]   result_next;
    logic [W-1:0]   high_reg;
    logic [W-1:0]   high_next;
    logic           dz_reg;
    logic [W-1:0]   q_val;
    logic [W-1:0]   r_val;

    assign busy = 1'b0;

    iea_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (start & ~busy),
        .kind       (kind),
        .src_a      (src_a),
        .src_b      (src_b),
        .offset     (offset),
        .full_width (full_width),
        .stage_out  (chain[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        iea_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    assign last = chain[W];

    always_comb
    begin
        q_val       = last.neg_q ? (W'(0) - last.quot) : last.quot;
        r_val       = last.neg_r ? (W'(0) - last.rem)  : last.rem;
        result_next = last.res;
        high_next   = last.high;
        if (last.dz)
        begin
            result_next = '0;
            high_next   = '0;
        end
        else
        begin
            case (last.kind)
                OP_REM, OP_REMU:
                begin
                    result_next = r_val;
                    high_next   = '0;
                end
                OP_DIV, OP_DIVU:
                begin
                    result_next = q_val;
                    high_next   = last.full ? r_val : '0;
                end
                default:
                begin
                    result_next = last.res;
                    high_next   = last.high;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        high_reg   <= high_next;
        dz_reg     <= last.dz;
    end

    assign done           = done_reg;
    assign result         = result_reg;
    assign high_part      = high_reg;
    assign divide_by_zero = dz_reg;

    `IEA_ASSERT_IMP(a_latency, start, ##LATENCY done, "request did not complete on time")
    `IEA_ASSERT_IMP(a_dz_zero, done && divide_by_zero, (result | high_part) == '0, "dz nonzero")
    `IEA_ASSERT_IMP(a_dz_kind, last.valid && last.dz, is_div_op(last.kind), "dz on non-divide")
    `IEA_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule
